>>> hdl/ltd_pkg.sv
`default_nettype none
// shared constants, payload types and register codes of the laplacian edge threshold core
// no dependencies; imported by every module of the block
package ltd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int THR_W    = 8;
  localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CMP_W    = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = (HEIGHT_W > WIDTH_W) ?
                             ((HEIGHT_W > THR_W) ? HEIGHT_W : THR_W) :
                             ((WIDTH_W > THR_W) ? WIDTH_W : THR_W);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = CFG_IDX_W'(2);

  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH    = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT   = HEIGHT_W'(768);
  localparam logic [THR_W-1:0]    RST_EDGE_THRESHOLD = THR_W'(0);

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] gray;
  } in_item_t;

  typedef struct packed {
    logic edge_res;
    logic frame_last;
  } out_item_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [THR_W-1:0]    thr;
  } cfg_t;

  // one pixel's neighborhood, border substitution already applied
  typedef struct packed {
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic             last;
  } job_t;

endpackage

`default_nettype wire

>>> hdl/ltd_front.sv
`default_nettype none
// front end: accepts pixel and drain transactions, keeps frame counters and the two row stores
// builds one neighborhood job per result; depends on ltd_pkg
module ltd_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire ltd_pkg::in_item_t            in_data,
  output logic                              full,
  input  wire logic [ltd_pkg::WIDTH_W-1:0]  img_width,
  input  wire logic [ltd_pkg::HEIGHT_W-1:0] img_height,
  output logic                              job_valid,
  output ltd_pkg::job_t                     job,
  input  wire logic                         job_full
);
  import ltd_pkg::*;

  logic [PIX_W-1:0] prev_row_mem [MAX_WIDTH];
  logic [PIX_W-1:0] pprev_row_mem [MAX_WIDTH];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] drain_r, drain_nxt;
  logic             draining_r, draining_nxt;
  logic             s1_valid_r, s1_valid_nxt;

  logic             s1_push_r;
  logic [COL_W-1:0] s1_addr_r;
  logic             s1_left_c_r, s1_right_c_r, s1_up_c_r, s1_down_c_r, s1_last_r;
  logic [PIX_W-1:0] s1_gray_r;
  logic [PIX_W-1:0] rd_centre_r, rd_right_r, rd_up_r;
  logic [PIX_W-1:0] held_r;

  logic             acc, s1_fire, is_push, is_drain, produce, up_hit;
  logic [COL_W-1:0] addr, addr_next;
  logic [CMP_W-1:0] pos_inc;
  logic             at_row_end, at_last_row;
  logic [PIX_W-1:0] centre;

  assign s1_fire   = s1_valid_r && !job_full;
  assign full      = s1_valid_r && job_full;
  assign acc       = push && !full;
  assign is_push   = acc && (in_data.func == FUNC_PUSH) && !draining_r;
  assign is_drain  = acc && (in_data.func == FUNC_DRAIN) && draining_r;
  assign addr      = is_drain ? drain_r : col_r;
  assign addr_next = addr + COL_W'(1);
  assign pos_inc   = CMP_W'(addr) + CMP_W'(1);
  assign at_row_end  = pos_inc >= CMP_W'(img_width);
  assign at_last_row = (HEIGHT_W'(row_r) + HEIGHT_W'(1)) >= img_height;
  assign produce   = (is_push && (row_r != '0)) || is_drain;

  // pprev store is written when the registered job fires, after the read; forward that write
  assign up_hit    = s1_fire && s1_push_r && (s1_addr_r == addr);

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    drain_nxt    = drain_r;
    draining_nxt = draining_r;
    if (is_push) begin
      if (at_row_end) begin
        col_nxt = '0;
        if (at_last_row) begin
          draining_nxt = 1'b1;
          drain_nxt    = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = addr_next;
      end
    end else if (is_drain) begin
      if (at_row_end) begin
        draining_nxt = 1'b0;
        drain_nxt    = '0;
        row_nxt      = '0;
        col_nxt      = '0;
      end else begin
        drain_nxt = addr_next;
      end
    end
  end

  always_comb begin
    if (acc) begin
      s1_valid_nxt = produce;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      drain_r    <= '0;
      draining_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      drain_r    <= drain_nxt;
      draining_r <= draining_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // row stores, read data registered
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_centre_r <= prev_row_mem[addr];
      rd_right_r  <= prev_row_mem[addr_next];
      rd_up_r     <= up_hit ? centre : pprev_row_mem[addr];
    end
    if (is_push) begin
      prev_row_mem[col_r] <= in_data.gray;
    end
    if (s1_fire && s1_push_r) begin
      pprev_row_mem[s1_addr_r] <= centre;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_push_r    <= is_push;
      s1_addr_r    <= addr;
      s1_left_c_r  <= addr == '0;
      s1_right_c_r <= at_row_end;
      s1_up_c_r    <= is_push ? (row_r == ROW_W'(1)) : (row_r == '0);
      s1_down_c_r  <= is_drain;
      s1_last_r    <= is_drain && at_row_end;
      s1_gray_r    <= in_data.gray;
    end
    // left neighbor is the centre of the previous result in the same row
    if (s1_fire) begin
      held_r <= centre;
    end
  end

  assign centre     = rd_centre_r;
  assign job_valid  = s1_valid_r;
  assign job.centre = centre;
  assign job.up     = s1_up_c_r ? centre : rd_up_r;
  assign job.down   = s1_down_c_r ? centre : s1_gray_r;
  assign job.left   = s1_left_c_r ? centre : held_r;
  assign job.right  = s1_right_c_r ? centre : rd_right_r;
  assign job.last   = s1_last_r;

`ifndef SYNTHESIS
  a_drain_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> col_r == '0)
    else $error("column counter not parked while draining");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && job_full |=> s1_valid_r && $stable(rd_centre_r) && $stable(s1_addr_r))
    else $error("stalled job changed");

  a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(draining_r) |-> $past(is_push) && drain_r == '0)
    else $error("drain phase entered without a final push");
`endif

endmodule

`default_nettype wire

>>> hdl/ltd_job_q.sv
`default_nettype none
// two-entry queue of neighborhood jobs between front end and back end
// depends on ltd_pkg
module ltd_job_q (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  input  wire ltd_pkg::job_t wr_job,
  output logic               full,
  input  wire logic          rd_en,
  output logic               empty,
  output ltd_pkg::job_t      rd_job
);
  import ltd_pkg::*;

  job_t       slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       wr_acc, rd_acc;

  assign full   = cnt_r == 2'd2;
  assign empty  = cnt_r == 2'd0;
  assign wr_acc = wr_valid && !full;
  assign rd_acc = rd_en && !empty;
  assign rd_job = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_acc && !rd_acc) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_acc && !wr_acc) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_acc) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_acc) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_acc) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

`ifndef SYNTHESIS
  a_job_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("job queue over capacity");
`endif

endmodule

`default_nettype wire

>>> hdl/ltd_back.sv
`default_nettype none
// back end: laplacian response, clamp, threshold and two-entry result queue
// depends on ltd_pkg
module ltd_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      job_empty,
  input  wire ltd_pkg::job_t             job,
  output logic                           job_pop,
  input  wire logic [ltd_pkg::THR_W-1:0] thr,
  output logic                           empty,
  input  wire logic                      pop,
  output ltd_pkg::out_item_t             out_data
);
  import ltd_pkg::*;

  localparam int SUM_W = PIX_W + 3;

  out_item_t        res_r [2];
  logic [1:0]       cnt_r, cnt_nxt;
  logic             wr_ptr_r, rd_ptr_r;
  logic             out_full, pop_acc;
  logic [SUM_W-1:0] sum;
  logic [PIX_W-1:0] clamped;
  out_item_t        res;

  // 4*centre minus neighbors, two's complement in SUM_W bits
  assign sum = SUM_W'({job.centre, 2'b00}) - SUM_W'(job.up) - SUM_W'(job.down)
             - SUM_W'(job.left) - SUM_W'(job.right);

  always_comb begin
    if (sum[SUM_W-1]) begin
      clamped = '0;
    end else if (sum[SUM_W-2:PIX_W] != '0) begin
      clamped = '1;
    end else begin
      clamped = sum[PIX_W-1:0];
    end
  end

  assign res.edge_res   = clamped > thr;
  assign res.frame_last = job.last;

  assign out_full = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign job_pop  = !job_empty && !out_full;
  assign pop_acc  = pop && !empty;
  assign out_data = res_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (job_pop && !pop_acc) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_acc && !job_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (job_pop) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_acc) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      res_r[wr_ptr_r] <= res;
    end
  end

`ifndef SYNTHESIS
  a_res_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("result queue over capacity");
`endif

endmodule

`default_nettype wire

>>> hdl/laplacian_edge_threshold_core.sv
`default_nettype none
// a result passes the stage-1 registers, the job queue and the result queue after the
// transaction that completes it is accepted (the pixel below it, one row later, or a drain
// step for the last row); throughput: one transaction per cycle, set by the row store access
// and the combinational response datapath; stalls only when both internal queues fill
// reset: synchronous, active low; counters, queues and configuration registers return to
// their defaults, the row stores are not cleared and need no pass
module laplacian_edge_threshold_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire ltd_pkg::in_item_t             in_data,
  output logic                               full,
  output logic                               empty,
  input  wire logic                          pop,
  output ltd_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [ltd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ltd_pkg::CFG_W-1:0]     cfg_wdata
);
  import ltd_pkg::*;

  cfg_t cfg_r;
  logic job_valid, job_full, q_empty, job_pop;
  job_t front_job, head_job;

  function automatic logic [WIDTH_W-1:0] used_width(input logic [WIDTH_W-1:0] v);
    logic [WIDTH_W-1:0] r;
    if (v == '0) begin
      r = WIDTH_W'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = WIDTH_W'(MAX_WIDTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [HEIGHT_W-1:0] used_height(input logic [HEIGHT_W-1:0] v);
    logic [HEIGHT_W-1:0] r;
    if (v == '0) begin
      r = HEIGHT_W'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      r = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // registers hold the saturated values actually used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= used_width(RST_IMAGE_WIDTH);
      cfg_r.height <= used_height(RST_IMAGE_HEIGHT);
      cfg_r.thr    <= RST_EDGE_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          cfg_r.width <= used_width(cfg_wdata[WIDTH_W-1:0]);
        end
        REG_IMAGE_HEIGHT: begin
          cfg_r.height <= used_height(cfg_wdata[HEIGHT_W-1:0]);
        end
        REG_EDGE_THRESHOLD: begin
          cfg_r.thr <= cfg_wdata[THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  ltd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_data    (in_data),
    .full       (full),
    .img_width  (cfg_r.width),
    .img_height (cfg_r.height),
    .job_valid  (job_valid),
    .job        (front_job),
    .job_full   (job_full)
  );

  ltd_job_q u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (job_valid),
    .wr_job   (front_job),
    .full     (job_full),
    .rd_en    (job_pop),
    .empty    (q_empty),
    .rd_job   (head_job)
  );

  ltd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (q_empty),
    .job       (head_job),
    .job_pop   (job_pop),
    .thr       (cfg_r.thr),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for laplacian_edge_threshold_core: directed frames, then random frames
// checked against an in-bench edge predictor; depends on ltd_pkg and the core only
module tb_top;
  import ltd_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 29;
  localparam int NOISE_PCT     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_BINARY, PIX_SPARSE} pix_style_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    in_item_t             item;
    logic                 typed;
    out_item_t            typed_res;
  } dir_row_t;

  localparam out_item_t RES_BLACK      = '{1'b0, 1'b0};
  localparam out_item_t RES_EDGE       = '{1'b1, 1'b0};
  localparam out_item_t RES_BLACK_LAST = '{1'b0, 1'b1};
  localparam out_item_t RES_EDGE_LAST  = '{1'b1, 1'b1};

  localparam dir_row_t DIRECTED [30] = '{
    // 3x3 frame with one bright pixel in the middle
    '{ROW_CFG,  REG_IMAGE_WIDTH,    CFG_W'(3), '0, 1'b0, RES_BLACK},
    '{ROW_CFG,  REG_IMAGE_HEIGHT,   CFG_W'(3), '0, 1'b0, RES_BLACK},
    '{ROW_CFG,  REG_EDGE_THRESHOLD, CFG_W'(0), '0, 1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_DRAIN, 8'hA5}, 1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd0},   1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd0},   1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd0},   1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd0},   1'b1, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd255}, 1'b1, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd0},   1'b1, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd0},   1'b1, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd0},   1'b1, RES_EDGE},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd0},   1'b1, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'hFF},  1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_DRAIN, 8'd0},   1'b1, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_DRAIN, 8'd0},   1'b1, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_DRAIN, 8'd0},   1'b1, RES_BLACK_LAST},
    // single pixel frame: every neighbor is the pixel itself
    '{ROW_CFG,  REG_IMAGE_WIDTH,    CFG_W'(1), '0, 1'b0, RES_BLACK},
    '{ROW_CFG,  REG_IMAGE_HEIGHT,   CFG_W'(1), '0, 1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd200}, 1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_DRAIN, 8'd0},   1'b1, RES_BLACK_LAST},
    // 2x2 checkerboard, clamped response just over the threshold
    '{ROW_CFG,  REG_EDGE_THRESHOLD, CFG_W'(254), '0, 1'b0, RES_BLACK},
    '{ROW_CFG,  REG_IMAGE_WIDTH,    CFG_W'(2),   '0, 1'b0, RES_BLACK},
    '{ROW_CFG,  REG_IMAGE_HEIGHT,   CFG_W'(2),   '0, 1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd255}, 1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd0},   1'b0, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd0},   1'b1, RES_EDGE},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_PUSH,  8'd255}, 1'b1, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_DRAIN, 8'd0},   1'b1, RES_BLACK},
    '{ROW_ITEM, REG_UNUSED, '0, '{FUNC_DRAIN, 8'd0},   1'b1, RES_EDGE_LAST}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 push;
  in_item_t             in_data;
  logic                 full;
  logic                 empty;
  logic                 pop;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // predictor state
  logic [WIDTH_W-1:0]  cfg_width  = RST_IMAGE_WIDTH;
  logic [HEIGHT_W-1:0] cfg_height = RST_IMAGE_HEIGHT;
  logic [THR_W-1:0]    cfg_thr    = RST_EDGE_THRESHOLD;
  logic [PIX_W-1:0]    line_prev  [MAX_WIDTH];
  logic [PIX_W-1:0]    line_prev2 [MAX_WIDTH];
  int                  push_col   = 0;
  int                  push_row   = 0;
  int                  drain_col  = 0;
  bit                  draining   = 1'b0;
  int                  held_left  = 0;
  int                  frames_done = 0;

  out_item_t pending_edges [$];
  out_item_t want;
  int        mismatches    = 0;
  int        random_items  = 0;
  int        cycle_count   = 0;
  int        hold_requests = 0;
  int        hold_served   = 0;
  bit        steady        = 1'b0;

  laplacian_edge_threshold_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic edge_bit(input int centre, input int up, input int down,
                                    input int left, input int right);
    int s;
    s = 4 * centre - up - down - left - right;
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return s > int'(cfg_thr);
  endfunction

  // one transaction into the edge predictor; returns 1 when it yields a result
  function automatic bit predict_edge(input in_item_t it, output out_item_t res);
    int w, h, c, centre, up, left, right;
    bit produced;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height));
    res = '0;
    produced = 1'b0;
    if (it.func == FUNC_PUSH) begin
      c = push_col;
      if (draining || c >= MAX_WIDTH) return 1'b0;
      if (push_row == 0) begin
        line_prev[c] = it.gray;
      end else begin
        centre = line_prev[c];
        left   = (c == 0) ? centre : held_left;
        right  = (c + 1 < w) ? int'(line_prev[c + 1]) : centre;
        up     = (push_row == 1) ? centre : int'(line_prev2[c]);
        res.edge_res  = edge_bit(centre, up, int'(it.gray), left, right);
        held_left     = centre;
        line_prev2[c] = PIX_W'(centre);
        line_prev[c]  = it.gray;
        produced      = 1'b1;
      end
      if (c + 1 >= w) begin
        push_col = 0;
        if (push_row + 1 >= h) begin
          draining  = 1'b1;
          drain_col = 0;
        end else begin
          push_row++;
        end
      end else begin
        push_col = c + 1;
      end
      return produced;
    end
    c = drain_col;
    if (!draining || c >= MAX_WIDTH) return 1'b0;
    centre = line_prev[c];
    left   = (c == 0) ? centre : int'(line_prev[c - 1]);
    right  = (c + 1 < w) ? int'(line_prev[c + 1]) : centre;
    up     = (push_row == 0) ? centre : int'(line_prev2[c]);
    res.edge_res   = edge_bit(centre, up, centre, left, right);
    res.frame_last = (c + 1 >= w);
    if (res.frame_last) begin
      draining  = 1'b0;
      drain_col = 0;
      push_row  = 0;
      push_col  = 0;
      frames_done++;
    end else begin
      drain_col = c + 1;
    end
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] pick_gray(input pix_style_e style, input int base);
    int r, v;
    r = $urandom_range(0, 12);
    case (style)
      PIX_SMOOTH: begin
        v = base + r - 6;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      PIX_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
      PIX_SPARSE: v = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 255)) : base;
      default:    v = $urandom_range(0, 255);
    endcase
    return PIX_W'(v);
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 255 : 0;
      1:       return $urandom_range(0, 40);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t typed_res);
    out_item_t res;
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        push <= 1'b0;
        @(negedge clk);
      end
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    if (predict_edge(it, res)) pending_edges.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    // row-0 pixels give no result, so let the pipeline settle
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_W-1:0] wd;
    wd = CFG_W'($urandom);
    case (idx)
      REG_IMAGE_WIDTH: begin
        wd[WIDTH_W-1:0] = WIDTH_W'(val);
        cfg_width       = WIDTH_W'(val);
      end
      REG_IMAGE_HEIGHT: begin
        wd[HEIGHT_W-1:0] = HEIGHT_W'(val);
        cfg_height       = HEIGHT_W'(val);
      end
      REG_EDGE_THRESHOLD: begin
        wd[THR_W-1:0] = THR_W'(val);
        cfg_thr       = THR_W'(val);
      end
      default: ;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wd;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_frame(input int w, input int h, input int thr);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_EDGE_THRESHOLD, thr);
  endtask

  // runs the current frame to its last drain, with a few ignored transactions mixed in
  task automatic run_frame(input pix_style_e style, input int base);
    int       start_frames;
    bit       noise;
    in_item_t it;
    start_frames = frames_done;
    while (frames_done == start_frames) begin
      noise   = ($urandom_range(0, 99) < NOISE_PCT);
      it.func = (draining ^ noise) ? FUNC_DRAIN : FUNC_PUSH;
      it.gray = pick_gray(style, base);
      send_item(it, 1'b0, RES_BLACK);
      if (!noise) random_items++;
    end
  endtask

  task automatic random_phase();
    int w, frames;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
    program_frame(w, $urandom_range(0, 6), pick_threshold());
    frames = $urandom_range(1, 3);
    repeat (frames) run_frame(pix_style_e'($urandom_range(0, 3)), $urandom_range(0, 255));
  endtask

  initial begin
    in_item_t it;
    int       mark;
    rst_n     = 1'b0;
    push      = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIRECTED[i].reg_idx, int'(DIRECTED[i].reg_val));
      end else begin
        send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].typed_res);
      end
    end

    while (random_items < 300) random_phase();

    // width register above the maximum, row 0 partly filled, then the width is narrowed
    // no idling on either side
    steady = 1'b1;
    program_frame(2047, 2, pick_threshold());
    repeat (48) begin
      it.func = FUNC_PUSH;
      it.gray = pick_gray(PIX_NOISE, 0);
      send_item(it, 1'b0, RES_BLACK);
    end
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 48);
    run_frame(PIX_NOISE, 0);
    steady = 1'b0;

    // zero width and height above the maximum; receiver holds off while rows keep coming
    program_frame(0, 8191, pick_threshold());
    hold_requests++;
    repeat (60) begin
      it.func = FUNC_PUSH;
      it.gray = pick_gray(PIX_SPARSE, 128);
      send_item(it, 1'b0, RES_BLACK);
    end
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 64);
    run_frame(PIX_SPARSE, $urandom_range(0, 255));

    // narrower and shorter frame set in the middle of row 2
    program_frame(10, 5, 30);
    repeat (25) begin
      it.func = FUNC_PUSH;
      it.gray = pick_gray(PIX_NOISE, 0);
      send_item(it, 1'b0, RES_BLACK);
    end
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 4);
    write_reg(REG_IMAGE_HEIGHT, 4);
    write_reg(REG_EDGE_THRESHOLD, 100);
    write_reg(REG_UNUSED, 0);
    run_frame(PIX_NOISE, 0);

    mark = random_items;
    while (random_items < mark + 550) random_phase();

    push <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          pop <= 1'b0;
          @(negedge clk);
        end
        hold_served++;
      end
      pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_edges.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, actual edge_res %0b frame_last %0b",
                 $time, out_data.edge_res, out_data.frame_last);
      end else begin
        want = pending_edges.pop_front();
        if (out_data.edge_res !== want.edge_res) begin
          mismatches++;
          $display("%0t: edge_res mismatch, expected %0b actual %0b",
                   $time, want.edge_res, out_data.edge_res);
        end
        if (out_data.frame_last !== want.frame_last) begin
          mismatches++;
          $display("%0t: frame_last mismatch, expected %0b actual %0b",
                   $time, want.frame_last, out_data.frame_last);
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
